/* rtl/cost_keyed_entry_set_macros.svh */
// assertion helpers for the entry set, empty when synthesizing
`ifndef COST_KEYED_ENTRY_SET_MACROS_SVH
`define COST_KEYED_ENTRY_SET_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked on every rising edge out of reset
`define CKES_ASSERT_IMPLY(label, clk, rst, cond, conseq) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error("entry set check failed");

// next-cycle implication
`define CKES_ASSERT_NEXT(label, clk, rst, cond, conseq) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error("entry set check failed");

`else

`define CKES_ASSERT_IMPLY(label, clk, rst, cond, conseq)
`define CKES_ASSERT_NEXT(label, clk, rst, cond, conseq)

`endif

`endif

/* rtl/ckes_pkg.sv */
`timescale 1ns / 1ps

package ckes_pkg;

  // command codes
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_FIND   = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_LOWEST = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_DUP   = 2'd3;

  // cost key selectors, any other code picks f
  localparam logic [1:0] KEY_F = 2'd0;
  localparam logic [1:0] KEY_G = 2'd1;
  localparam logic [1:0] KEY_H = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic load;    // latch the accepted item and start a walk
    logic walk;    // step the store walk one entry
    logic seek;    // point the walk just past the removed entry
    logic move;    // walk copies each entry one place down
    logic commit;  // apply the command and load the result register
  } ckes_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic walk_done;   // no read in flight and no entry left to read
    logic need_shift;  // remove found its entry, gap must close
  } ckes_stat_t;

endpackage

/* rtl/ckes_ram.sv */
`timescale 1ns / 1ps

module ckes_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/ckes_datapath.sv */
`timescale 1ns / 1ps

module ckes_datapath
  import ckes_pkg::*;
#(
  parameter int ENTRIES   = 64,
  parameter int ID_BITS   = 16,
  parameter int COST_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  ckes_cmd_t                        cmd,
  output ckes_stat_t                       stat,
  input  logic [1:0]                       in_op,
  input  logic [ID_BITS-1:0]               in_id,
  input  logic [COST_BITS-1:0]             in_f,
  input  logic [COST_BITS-1:0]             in_g,
  input  logic [COST_BITS-1:0]             in_h,
  input  logic [1:0]                       in_key,
  output logic                             res_hit,
  output logic [ID_BITS-1:0]               res_id,
  output logic [$clog2(ENTRIES+1)-1:0]     res_count,
  output logic [1:0]                       res_status
);

  localparam int IDX_BITS = $clog2(ENTRIES);
  localparam int CNT_BITS = $clog2(ENTRIES + 1);
  localparam int ENT_W    = ID_BITS + 3 * COST_BITS;

  // latched command
  logic [1:0]           op;
  logic [ID_BITS-1:0]   id_q;
  logic [COST_BITS-1:0] f_q;
  logic [COST_BITS-1:0] g_q;
  logic [COST_BITS-1:0] h_q;
  logic [1:0]           key_q;

  // walk and search state
  logic [CNT_BITS-1:0]  count;
  logic [CNT_BITS-1:0]  count_next;
  logic [CNT_BITS-1:0]  addr;
  logic                 rd_pend;
  logic [IDX_BITS-1:0]  pend_idx;
  logic                 found;
  logic [IDX_BITS-1:0]  found_pos;
  logic                 best_valid;
  logic [COST_BITS-1:0] best_cost;
  logic [ID_BITS-1:0]   best_id;

  // store port signals
  logic                 ram_we;
  logic [IDX_BITS-1:0]  ram_waddr;
  logic [ENT_W-1:0]     ram_wdata;
  logic [ENT_W-1:0]     rdata;

  logic                 issue;
  logic [ID_BITS-1:0]   rd_id;
  logic [COST_BITS-1:0] rd_cost;
  logic                 id_match;
  logic                 take_best;
  logic                 full;
  logic                 ins_ok;
  logic                 hit_next;
  logic [ID_BITS-1:0]   rid_next;
  logic [1:0]           st_next;

  ckes_ram #(
    .WIDTH(ENT_W),
    .DEPTH(ENTRIES)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(addr[IDX_BITS-1:0]),
    .rdata(rdata)
  );

  // entry layout: f lowest, then g, h, id on top
  assign rd_id = rdata[ENT_W-1 -: ID_BITS];

  always_comb begin
    unique case (key_q)
      KEY_G:   rd_cost = rdata[2*COST_BITS-1 -: COST_BITS];
      KEY_H:   rd_cost = rdata[3*COST_BITS-1 -: COST_BITS];
      default: rd_cost = rdata[COST_BITS-1:0];
    endcase
  end

  // walk issues one read per cycle while entries remain
  assign issue     = (addr < count);
  assign id_match  = rd_pend && !cmd.move && (rd_id == id_q);
  // later entries are newer, so ties move the pick forward
  assign take_best = rd_pend && !cmd.move && (!best_valid || rd_cost <= best_cost);

  assign stat.walk_done  = !issue && !rd_pend;
  assign stat.need_shift = (op == OP_REMOVE) && found;

  // command outcome
  assign full   = (count == CNT_BITS'(ENTRIES));
  assign ins_ok = (op == OP_INSERT) && !found && !full;

  always_comb begin
    hit_next   = 1'b0;
    rid_next   = '0;
    st_next    = ST_OK;
    count_next = count;
    unique case (op)
      OP_INSERT: begin
        if (found) begin
          st_next = ST_DUP;
        end else if (full) begin
          st_next = ST_FULL;
        end else begin
          count_next = count + CNT_BITS'(1);
        end
      end
      OP_FIND: begin
        hit_next = found;
        rid_next = found ? id_q : '0;
      end
      OP_REMOVE: begin
        hit_next = found;
        rid_next = found ? id_q : '0;
        if (found) begin
          count_next = count - CNT_BITS'(1);
        end
      end
      default: begin
        if (count == '0) begin
          st_next = ST_EMPTY;
        end else begin
          hit_next = 1'b1;
          rid_next = best_id;
        end
      end
    endcase
  end

  // store writes: compaction copy or a new entry at the tail
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = count[IDX_BITS-1:0];
    ram_wdata = {id_q, h_q, g_q, f_q};
    if (cmd.move && rd_pend) begin
      ram_we    = 1'b1;
      ram_waddr = pend_idx - IDX_BITS'(1);
      ram_wdata = rdata;
    end else if (cmd.commit && ins_ok) begin
      ram_we = 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      addr       <= '0;
      rd_pend    <= 1'b0;
      found      <= 1'b0;
      best_valid <= 1'b0;
    end else begin
      if (cmd.load) begin
        addr       <= '0;
        rd_pend    <= 1'b0;
        found      <= 1'b0;
        best_valid <= 1'b0;
      end else begin
        if (cmd.seek) begin
          addr <= CNT_BITS'(found_pos) + CNT_BITS'(1);
        end else if (cmd.walk && issue) begin
          addr <= addr + CNT_BITS'(1);
        end
        rd_pend <= cmd.walk && !cmd.seek && issue;
        if (cmd.walk && id_match) begin
          found <= 1'b1;
        end
        if (cmd.walk && take_best) begin
          best_valid <= 1'b1;
        end
      end
      if (cmd.commit) begin
        count <= count_next;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op    <= in_op;
      id_q  <= in_id;
      f_q   <= in_f;
      g_q   <= in_g;
      h_q   <= in_h;
      key_q <= in_key;
    end
    pend_idx <= addr[IDX_BITS-1:0];
    if (cmd.walk && id_match && !found) begin
      found_pos <= pend_idx;
    end
    if (cmd.walk && take_best) begin
      best_cost <= rd_cost;
      best_id   <= rd_id;
    end
    if (cmd.commit) begin
      res_hit    <= hit_next;
      res_id     <= rid_next;
      res_count  <= count_next;
      res_status <= st_next;
    end
  end

endmodule

/* rtl/ckes_ctrl.sv */
`timescale 1ns / 1ps

module ckes_ctrl
  import ckes_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  output logic       m_tvalid,
  input  logic       m_tready,
  input  ckes_stat_t stat,
  output ckes_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_free;

  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;

  // sequencing of one command
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.walk = 1'b1;
        if (stat.walk_done) begin
          if (stat.need_shift) begin
            cmd.seek   = 1'b1;
            state_next = S_SHIFT;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_SHIFT: begin
        cmd.walk = 1'b1;
        cmd.move = 1'b1;
        if (stat.walk_done) begin
          state_next = S_DONE;
        end
      end
      default: begin
        if (out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
    endcase
  end

  // state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.commit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

/* rtl/cost_keyed_entry_set.sv */
`timescale 1ns / 1ps
// channel  | direction | transfer contents
// s_*      | in        | tuser: command; tdata: tile_id, cost_f, cost_g, cost_h, key_select
// m_*      | out       | tuser: status; tdata: hit, result_id, entry_count
//
// every command walks the held entries through the store's single read port,
// one entry per cycle; a remove that hits then walks the entries after the
// removed one again and copies each one place down to close the gap.
// reset clears the entry count and control; store contents stay undefined.
// a result waits in the output register while the next item is taken in;
// commit stalls only when that register is still full.

`include "cost_keyed_entry_set_macros.svh"

module cost_keyed_entry_set
  import ckes_pkg::*;
#(
  parameter int ENTRIES   = 64,
  parameter int ID_BITS   = 16,
  parameter int COST_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // from bit 0: tile_id, cost_f, cost_g, cost_h, key_select, zero fill
  input  logic [((ID_BITS+3*COST_BITS+2+7)/8)*8-1:0] s_tdata,
  // command
  input  logic [1:0]            s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // from bit 0: hit, result_id, entry_count, zero fill
  output logic [((1+ID_BITS+$clog2(ENTRIES+1)+7)/8)*8-1:0] m_tdata,
  // status
  output logic [1:0]            m_tuser
);

  localparam int CNT_BITS = $clog2(ENTRIES + 1);
  localparam int OUT_W    = ((1 + ID_BITS + CNT_BITS + 7) / 8) * 8;
  localparam int F_LO     = ID_BITS;
  localparam int G_LO     = ID_BITS + COST_BITS;
  localparam int H_LO     = ID_BITS + 2 * COST_BITS;
  localparam int K_LO     = ID_BITS + 3 * COST_BITS;

  ckes_cmd_t               cmd;
  ckes_stat_t              stat;
  logic                    res_hit;
  logic [ID_BITS-1:0]      res_id;
  logic [CNT_BITS-1:0]     res_count;

  ckes_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .stat    (stat),
    .cmd     (cmd)
  );

  ckes_datapath #(
    .ENTRIES  (ENTRIES),
    .ID_BITS  (ID_BITS),
    .COST_BITS(COST_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_op     (s_tuser),
    .in_id     (s_tdata[ID_BITS-1:0]),
    .in_f      (s_tdata[F_LO +: COST_BITS]),
    .in_g      (s_tdata[G_LO +: COST_BITS]),
    .in_h      (s_tdata[H_LO +: COST_BITS]),
    .in_key    (s_tdata[K_LO +: 2]),
    .res_hit   (res_hit),
    .res_id    (res_id),
    .res_count (res_count),
    .res_status(m_tuser)
  );

  // result packing
  assign m_tdata = OUT_W'({res_count, res_id, res_hit});

  // checks
  `CKES_ASSERT_NEXT(a_busy_after_take, clk, rst, s_tvalid && s_tready, !s_tready)
  `CKES_ASSERT_IMPLY(a_commit_slot_free, clk, rst, cmd.commit, !m_tvalid || m_tready)
  `CKES_ASSERT_NEXT(a_commit_shows, clk, rst, cmd.commit, m_tvalid)
  `CKES_ASSERT_IMPLY(a_empty_no_hit, clk, rst, m_tvalid && m_tuser == ST_EMPTY, !res_hit)

endmodule
